>>> rtl/wspm_pkg.sv
// Shared constants, register indexes and cell link types for the pattern matcher.
package wspm_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int BYTE_W           = 8;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int MASK_W           = 16;
  localparam int COUNT_W          = 5;
  localparam int BYTES_PER_REG    = CFG_DATA_W / BYTE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_LOW     = 3'd0,
    CFG_BYTES_HIGH    = 3'd1,
    CFG_STAR_MASK     = 3'd2,
    CFG_ANY_MASK      = 3'd3,
    CFG_ELEMENT_COUNT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              in_text;
    logic              step;
    logic              clear;
    logic [BYTE_W-1:0] text_byte;
  } cell_ctl_t;

  typedef struct packed {
    logic cur;
    logic start;
    logic nxt;
  } cell_link_t;

endpackage

>>> rtl/wspm_if.sv
// Handshake channel interfaces for text words, result words and register writes.
interface wspm_text_if;
  logic                       valid;
  logic                       ready;
  logic [wspm_pkg::BYTE_W-1:0] text_byte;
  logic                       byte_present;
  logic                       final_byte;

  modport source (output valid, text_byte, byte_present, final_byte, input ready);
  modport sink (input valid, text_byte, byte_present, final_byte, output ready);
endinterface

interface wspm_result_if;
  logic valid;
  logic ready;
  logic full_match;
  logic text_end;

  modport source (output valid, full_match, text_end, input ready);
  modport sink (input valid, full_match, text_end, output ready);
endinterface

interface wspm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wspm_pkg::CFG_IDX_W-1:0]  index;
  logic [wspm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wspm_cell.sv
// One pattern element cell: holds one prefix match bit and ripples star closure rightward.
module wspm_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  wspm_pkg::cell_ctl_t         ctl,
  input  logic [wspm_pkg::BYTE_W-1:0] elem_byte,
  input  logic                        star,
  input  logic                        any,
  input  logic                        active,
  input  wspm_pkg::cell_link_t        left,
  output wspm_pkg::cell_link_t        right,
  output logic                        row_bit
);
  import wspm_pkg::*;

  logic row;
  logic row_next;
  logic hit;
  logic start_bit;
  logic cur_bit;
  logic nxt_bit;

  always_comb begin
    hit       = any | (elem_byte == ctl.text_byte);
    start_bit = active & left.start & star;
    cur_bit   = ctl.in_text ? row : start_bit;
    if (star) begin
      nxt_bit = active & (left.nxt | (cur_bit & hit));
    end else begin
      nxt_bit = active & left.cur & hit;
    end
    right.start = start_bit;
    right.cur   = cur_bit;
    right.nxt   = nxt_bit;
  end

  always_comb begin
    priority if (ctl.clear) begin
      row_next = 1'b0;
    end else if (ctl.step) begin
      row_next = nxt_bit;
    end else begin
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 1'b0;
    end else begin
      row <= row_next;
    end
  end

  assign row_bit = row;

endmodule

>>> rtl/wildcard_star_pattern_matcher_unit.sv
// Top level of the wildcard star pattern matcher: registers, cell chain and result register.
// The result word of an accepted text word is registered and valid in the cycle after acceptance.
// Throughput: one text word per cycle unless backpressure stalls; the row update ripples once through the cell chain.
// Backpressure holds the result register; input is taken whenever it is empty or draining.
// Reset (rst, synchronous) clears config registers, out_valid, match row and inside-text flag.
module wildcard_star_pattern_matcher_unit #(
  parameter int MAX_ELEMENTS = wspm_pkg::MAX_ELEMENTS_DEF
) (
  input logic          clk,
  input logic          rst,
  wspm_text_if.sink    text_in,
  wspm_result_if.source result_out,
  wspm_cfg_if.sink     cfg
);
  import wspm_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);

  logic [CFG_DATA_W-1:0] bytes_low;
  logic [CFG_DATA_W-1:0] bytes_high;
  logic [MASK_W-1:0]     star_mask;
  logic [MASK_W-1:0]     any_mask;
  logic [COUNT_W-1:0]    element_count;

  logic [2*BYTES_PER_REG-1:0][BYTE_W-1:0] elem_bytes;
  logic [IDX_W-1:0]                       used_count;

  logic              inside_text;
  logic              inside_text_next;
  logic              in_acc;
  logic              out_valid;
  logic              full_match_q;
  logic              text_end_q;
  logic              match_bit;
  cell_ctl_t         ctl;
  cell_link_t        link [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS:0] cur_vec;
  logic [MAX_ELEMENTS:0] nxt_vec;
  logic [MAX_ELEMENTS:0] sel_vec;
  logic [MAX_ELEMENTS:1] row_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_low     <= '0;
      bytes_high    <= '0;
      star_mask     <= '0;
      any_mask      <= '0;
      element_count <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_BYTES_LOW:     bytes_low     <= cfg.data;
        CFG_BYTES_HIGH:    bytes_high    <= cfg.data;
        CFG_STAR_MASK:     star_mask     <= cfg.data[MASK_W-1:0];
        CFG_ANY_MASK:      any_mask      <= cfg.data[MASK_W-1:0];
        CFG_ELEMENT_COUNT: element_count <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign elem_bytes = {bytes_high, bytes_low};
  assign used_count = (element_count > COUNT_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS)
                                                               : element_count[IDX_W-1:0];

  assign text_in.ready = !out_valid || result_out.ready;
  assign in_acc        = text_in.valid && text_in.ready;

  always_comb begin
    ctl.in_text   = inside_text;
    ctl.step      = in_acc & text_in.byte_present;
    ctl.clear     = in_acc & text_in.final_byte;
    ctl.text_byte = text_in.text_byte;
  end

  assign link[0].cur   = !inside_text;
  assign link[0].start = 1'b1;
  assign link[0].nxt   = 1'b0;

  for (genvar j = 1; j <= MAX_ELEMENTS; j++) begin : g_cell
    wspm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .elem_byte (elem_bytes[j-1]),
      .star      (star_mask[j-1]),
      .any       (any_mask[j-1]),
      .active    (IDX_W'(j) <= used_count),
      .left      (link[j-1]),
      .right     (link[j]),
      .row_bit   (row_q[j])
    );
  end

  for (genvar j = 0; j <= MAX_ELEMENTS; j++) begin : g_vec
    assign cur_vec[j] = link[j].cur;
    assign nxt_vec[j] = link[j].nxt;
  end

  assign sel_vec   = text_in.byte_present ? nxt_vec : cur_vec;
  assign match_bit = sel_vec[used_count];

  always_comb begin
    priority if (ctl.clear) begin
      inside_text_next = 1'b0;
    end else if (ctl.step) begin
      inside_text_next = 1'b1;
    end else begin
      inside_text_next = inside_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_text <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      inside_text <= inside_text_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      full_match_q <= match_bit;
      text_end_q   <= text_in.final_byte;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.full_match = full_match_q;
  assign result_out.text_end   = text_end_q;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted word produced no result");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && text_in.final_byte) |=> (!inside_text && row_q == '0))
    else $error("final word did not clear the match row");

  a_byte_opens_text: assert property (@(posedge clk) disable iff (rst)
    (in_acc && text_in.byte_present && !text_in.final_byte) |=> inside_text)
    else $error("consumed byte did not open a text");

  a_idle_row_clear: assert property (@(posedge clk) disable iff (rst)
    !inside_text |-> (row_q == '0))
    else $error("match row holds bits outside a text");

endmodule
